>>> src/stnl_pkg.sv
// ----------------------------------------------------------------------------
// stnl_pkg: shared types and constants of the sorted table lookup
// Table geometry, item and result codes, and the word passed from the
// front end to the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package stnl_pkg;

  // Table geometry
  localparam int TableDepth = 64;
  localparam int EnergyW    = 32;
  localparam int TagW       = 8;
  localparam int RankW      = 6;
  localparam int CountW     = $clog2(TableDepth + 1);

  // Queue between front end and table engine
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCountW    = $clog2(QueueDepth + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEL,
    S_PICK
  } eng_state_e;

  // Classified word: insert key or saturated lookup query
  typedef struct packed {
    op_e                op;
    logic [EnergyW-1:0] key;
    logic [TagW-1:0]    tag;
  } item_t;

endpackage : stnl_pkg

`default_nettype wire

>>> src/sorted_table_nearest_lookup.sv
// ----------------------------------------------------------------------------
// sorted_table_nearest_lookup: sorted energy table with nearest lookup
//
// Input channel: a queue port (push / full). An insert word places its
// energy and tag at the lower-bound position of the ascending table; a
// lookup word returns the entry nearest to energy minus offset (saturated
// at zero), ties going to the upper neighbor, queries above the table
// clamping to the top entry.
// Result channel: a queue port (empty / pop); one result word per input word,
// in order, held on the ports while empty is low.
// Sequencing: the table engine handles one word at a time, an insert through
// its compare and select steps and a lookup through compare, select and pick;
// it takes the next word from the queue only once the result is written.
// A two-word work queue sits in front of the engine, so full rises only when
// the queue holds two words and the engine is busy.
// Stall: while the result is not popped the engine holds its next result,
// the queue fills and full rises; nothing is lost.
// Reset: the table is empty after reset, no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_nearest_lookup import stnl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode_i,
  input  wire logic [EnergyW-1:0] energy_i,
  input  wire logic [EnergyW-1:0] offset_i,
  input  wire logic [TagW-1:0]    tag_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status_o,
  output logic [RankW-1:0]        rank_o,
  output logic [EnergyW-1:0]      found_energy_o,
  output logic [TagW-1:0]         found_tag_o
);

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wr_item, q_rd_item;

  // Classify incoming words
  stnl_front u_front (
    .push     (push),
    .full     (full),
    .opcode_i (opcode_i),
    .energy_i (energy_i),
    .offset_i (offset_i),
    .tag_i    (tag_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_wr_item)
  );

  // Decouple front end and engine
  stnl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  // Carry out inserts and lookups
  stnl_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (q_rd_item),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .rank_o         (rank_o),
    .found_energy_o (found_energy_o),
    .found_tag_o    (found_tag_o)
  );

endmodule : sorted_table_nearest_lookup

`default_nettype wire

>>> src/stnl_front.sv
// ----------------------------------------------------------------------------
// stnl_front: input front end
// Accepts words from the input queue port, forms the lookup query with a
// saturating subtract and hands a classified word to the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stnl_front import stnl_pkg::*; (
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode_i,
  input  wire logic [EnergyW-1:0] energy_i,
  input  wire logic [EnergyW-1:0] offset_i,
  input  wire logic [TagW-1:0]    tag_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output item_t                   q_item_o
);

  logic [EnergyW:0] diff;
  op_e              op;

  // Back-pressure follows the work queue
  assign full     = q_full_i;
  assign q_push_o = push & ~q_full_i;

  // Classify and build the key, saturating the query at zero
  always_comb begin
    op   = op_e'(opcode_i);
    diff = {1'b0, energy_i} - {1'b0, offset_i};
    q_item_o.op  = op;
    q_item_o.tag = tag_i;
    if (op == OP_LOOKUP) begin
      q_item_o.key = diff[EnergyW] ? '0 : diff[EnergyW-1:0];
    end else begin
      q_item_o.key = energy_i;
    end
  end

endmodule : stnl_front

`default_nettype wire

>>> src/stnl_queue.sv
// ----------------------------------------------------------------------------
// stnl_queue: short work queue
// Register queue between the front end and the table engine so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module stnl_queue import stnl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);

  item_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCountW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCountW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule : stnl_queue

`default_nettype wire

>>> src/stnl_engine.sv
// ----------------------------------------------------------------------------
// stnl_engine: sorted table engine
// Row of table cells that compare against the key in parallel; inserts
// shift cells at and above the lower bound, lookups pick the nearer neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module stnl_engine import stnl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  item_t                   q_item_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status_o,
  output logic [RankW-1:0]        rank_o,
  output logic [EnergyW-1:0]      found_energy_o,
  output logic [TagW-1:0]         found_tag_o
);

  // Table cells and occupancy
  logic [EnergyW-1:0] cell_e_q [TableDepth];
  logic [TagW-1:0]    cell_t_q [TableDepth];
  logic [CountW-1:0]  count_q, count_d;

  // Current word and compare vector
  eng_state_e            state_q, state_d;
  item_t                 cur_q;
  logic [TableDepth-1:0] lt_q, lt_d;
  logic                  load_cur;

  // Neighbor selection registers
  logic [EnergyW-1:0] up_e_q, dn_e_q, up_e, dn_e;
  logic [TagW-1:0]    up_t_q, dn_t_q, up_t, dn_t;
  logic [CountW-1:0]  pos_q, pos;
  logic               top_q, top;
  logic               load_sel;

  // Lower-bound decode
  logic [TableDepth-1:0] lb;
  logic                  lb_top;

  // Result register
  logic               res_vld_q, res_vld_d;
  status_e            res_st_q, res_st_d;
  logic [RankW-1:0]   res_rank_q, res_rank_d;
  logic [EnergyW-1:0] res_e_q, res_e_d;
  logic [TagW-1:0]    res_t_q, res_t_d;
  logic               res_we, slot_free, shift_en;

  // Pick stage arithmetic
  logic [EnergyW-1:0] up_dist, dn_dist;

  assign empty          = ~res_vld_q;
  assign status_o       = res_st_q;
  assign rank_o         = res_rank_q;
  assign found_energy_o = res_e_q;
  assign found_tag_o    = res_t_q;
  assign slot_free      = ~res_vld_q | pop;

  // Compare every valid cell against the incoming key
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      lt_d[i] = (CountW'(i) < count_q) && (cell_e_q[i] < q_item_i.key);
    end
  end

  // Decode the lower bound and gather both neighbors
  always_comb begin
    lb[0]  = ~lt_q[0];
    for (int i = 1; i < TableDepth; i++) begin
      lb[i] = ~lt_q[i] & lt_q[i-1];
    end
    lb_top = lt_q[TableDepth-1];
    pos    = lb_top ? CountW'(TableDepth) : '0;
    up_e   = '0;
    up_t   = '0;
    dn_e   = lb_top ? cell_e_q[TableDepth-1] : '0;
    dn_t   = lb_top ? cell_t_q[TableDepth-1] : '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (lb[i]) begin
        pos  = pos | CountW'(i);
        up_e = up_e | cell_e_q[i];
        up_t = up_t | cell_t_q[i];
      end
    end
    for (int i = 0; i < TableDepth - 1; i++) begin
      if (lb[i+1]) begin
        dn_e = dn_e | cell_e_q[i];
        dn_t = dn_t | cell_t_q[i];
      end
    end
    top = (pos == count_q);
  end

  assign up_dist = up_e_q - cur_q.key;
  assign dn_dist = cur_q.key - dn_e_q;

  // Sequence one word at a time and build its result
  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    load_cur   = 1'b0;
    load_sel   = 1'b0;
    shift_en   = 1'b0;
    count_d    = count_q;
    res_we     = 1'b0;
    res_st_d   = ST_OK;
    res_rank_d = '0;
    res_e_d    = '0;
    res_t_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          load_cur = 1'b1;
          state_d  = S_SEL;
        end
      end
      S_SEL: begin
        if (cur_q.op == OP_INSERT) begin
          if (slot_free) begin
            res_we  = 1'b1;
            state_d = S_IDLE;
            if (count_q == CountW'(TableDepth)) begin
              res_st_d = ST_FULL;
            end else begin
              shift_en   = 1'b1;
              count_d    = count_q + 1'b1;
              res_rank_d = pos[RankW-1:0];
            end
          end
        end else if (count_q == '0) begin
          if (slot_free) begin
            res_we   = 1'b1;
            res_st_d = ST_EMPTY;
            state_d  = S_IDLE;
          end
        end else begin
          load_sel = 1'b1;
          state_d  = S_PICK;
        end
      end
      S_PICK: begin
        if (slot_free) begin
          res_we  = 1'b1;
          state_d = S_IDLE;
          if (top_q || (pos_q != '0 && up_dist > dn_dist)) begin
            res_rank_d = RankW'(pos_q - 1'b1);
            res_e_d    = dn_e_q;
            res_t_d    = dn_t_q;
          end else begin
            res_rank_d = pos_q[RankW-1:0];
            res_e_d    = up_e_q;
            res_t_d    = up_t_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until it is popped
  always_comb begin
    res_vld_d = res_vld_q;
    if (pop && res_vld_q) begin
      res_vld_d = 1'b0;
    end
    if (res_we) begin
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Latch the word, its compare vector and the neighbors
  always_ff @(posedge clk_i) begin
    if (load_cur) begin
      cur_q <= q_item_i;
      lt_q  <= lt_d;
    end
    if (load_sel) begin
      up_e_q <= up_e;
      up_t_q <= up_t;
      dn_e_q <= dn_e;
      dn_t_q <= dn_t;
      pos_q  <= pos;
      top_q  <= top;
    end
    if (res_we) begin
      res_st_q   <= res_st_d;
      res_rank_q <= res_rank_d;
      res_e_q    <= res_e_d;
      res_t_q    <= res_t_d;
    end
  end

  // Shift cells at and above the lower bound, drop the new entry in place
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      if (!lt_q[0]) begin
        cell_e_q[0] <= cur_q.key;
        cell_t_q[0] <= cur_q.tag;
      end
      for (int i = 1; i < TableDepth; i++) begin
        if (!lt_q[i]) begin
          cell_e_q[i] <= lb[i] ? cur_q.key : cell_e_q[i-1];
          cell_t_q[i] <= lb[i] ? cur_q.tag : cell_t_q[i-1];
        end
      end
    end
  end

endmodule : stnl_engine

`default_nettype wire

>>> sim/sorted_table_nearest_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_nearest_lookup_tb: self-checking bench of the sorted table
// Walks a short table of insert and lookup words (empty table, extremes,
// duplicates, ties, clamping, saturated queries), then sends random words
// that fill the table and keep probing it once full. Every result word is
// compared field by field with a typed script reply or the table predictor;
// both sides idle at random, the result side twice for a long stretch.
// ----------------------------------------------------------------------------

module sorted_table_nearest_lookup_tb;
  import stnl_pkg::*;

  localparam int ClkHalf       = 2;
  localparam int ResetCycles   = 8;
  localparam int RandomWords   = 400;
  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;

  typedef struct packed {
    op_e                op;
    logic [EnergyW-1:0] energy;
    logic [EnergyW-1:0] offset;
    logic [TagW-1:0]    tag;
  } lookup_word_t;

  typedef struct packed {
    status_e            status;
    logic [RankW-1:0]   rank;
    logic [EnergyW-1:0] energy;
    logic [TagW-1:0]    tag;
  } table_reply_t;

  // One row of the directed script; typed rows carry their own reply
  typedef struct packed {
    lookup_word_t word;
    logic         typed;
    table_reply_t reply;
  } script_row_t;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               push     = 1'b0;
  logic               opcode_i = 1'b0;
  logic [EnergyW-1:0] energy_i = '0;
  logic [EnergyW-1:0] offset_i = '0;
  logic [TagW-1:0]    tag_i    = '0;
  logic               pop      = 1'b0;
  logic               full;
  logic               empty;
  logic [1:0]         status_o;
  logic [RankW-1:0]   rank_o;
  logic [EnergyW-1:0] found_energy_o;
  logic [TagW-1:0]    found_tag_o;

  // Predictor state: sorted energies, tags and fill level
  logic [EnergyW-1:0] model_energy [TableDepth];
  logic [TagW-1:0]    model_tag    [TableDepth];
  int                 model_count;

  table_reply_t replies_due[$];
  int mismatches    = 0;
  int replies_seen  = 0;
  int quiet_cycles  = 0;
  bit sender_steady = 1'b0;

  // Coverage tallies
  int n_inserts = 0, n_dropped = 0, n_lookups = 0, n_on_empty = 0;
  int n_ties = 0, n_clamped = 0, n_saturated = 0, n_holds = 0;

  sorted_table_nearest_lookup u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .energy_i       (energy_i),
    .offset_i       (offset_i),
    .tag_i          (tag_i),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .rank_o         (rank_o),
    .found_energy_o (found_energy_o),
    .found_tag_o    (found_tag_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Lower-bound search: first entry not below key, or the fill level
  function automatic int first_at_or_above(logic [EnergyW-1:0] key);
    for (int i = 0; i < model_count; i++) begin
      if (model_energy[i] >= key) return i;
    end
    return model_count;
  endfunction

  // Advance the predicted table by one word and return its result word
  function automatic table_reply_t predict_table_reply(lookup_word_t w);
    table_reply_t r;
    int pos;
    logic [EnergyW-1:0] query;
    r = '{ST_OK, '0, '0, '0};
    if (w.op == OP_INSERT) begin
      n_inserts++;
      if (model_count >= TableDepth) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        pos = first_at_or_above(w.energy);
        for (int i = model_count; i > pos; i--) begin
          model_energy[i] = model_energy[i-1];
          model_tag[i]    = model_tag[i-1];
        end
        model_energy[pos] = w.energy;
        model_tag[pos]    = w.tag;
        model_count++;
        r.rank = RankW'(pos);
      end
    end else begin
      n_lookups++;
      if (model_count == 0) begin
        r.status = ST_EMPTY;
        n_on_empty++;
      end else begin
        if (w.energy >= w.offset) begin
          query = w.energy - w.offset;
        end else begin
          query = '0;
          n_saturated++;
        end
        pos = first_at_or_above(query);
        if (pos == model_count) begin
          pos = model_count - 1;
          n_clamped++;
        end else if (pos > 0) begin
          if (model_energy[pos] - query == query - model_energy[pos-1]) n_ties++;
          if (model_energy[pos] - query > query - model_energy[pos-1]) pos--;
        end
        r.rank   = RankW'(pos);
        r.energy = model_energy[pos];
        r.tag    = model_tag[pos];
      end
    end
    return r;
  endfunction

  // Energy near something interesting: edges, stored entries, midpoints
  function automatic logic [EnergyW-1:0] pick_energy();
    int i;
    logic [EnergyW-1:0] lo_e, hi_e;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return EnergyW'($urandom_range(0, 63));
      2: return 32'hFFFF_FFFF - EnergyW'($urandom_range(0, 63));
      3: begin
        if (model_count > 0) begin
          i = $urandom_range(0, model_count - 1);
          return model_energy[i] + EnergyW'($urandom_range(0, 2)) - 1;
        end
      end
      default: begin
        if (model_count > 1) begin
          i    = $urandom_range(1, model_count - 1);
          lo_e = model_energy[i-1];
          hi_e = model_energy[i];
          return lo_e + (hi_e - lo_e) / 2;
        end
      end
    endcase
    return $urandom;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result
  task automatic send_word(lookup_word_t w, table_reply_t want);
    int gap;
    int r;
    gap = 0;
    if (!sender_steady) begin
      r = $urandom_range(0, 99);
      if (r >= 90)      gap = $urandom_range(10, 30);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    opcode_i <= w.op;
    energy_i <= w.energy;
    offset_i <= w.offset;
    tag_i    <= w.tag;
    do @(posedge clk_i); while (full);
    replies_due = {replies_due, want};
  endtask

  // Compare the word on the result ports with the oldest expectation
  task automatic check_reply();
    table_reply_t want;
    replies_seen++;
    if (replies_due.size() == 0) begin
      $error("unexpected result word: status %0d rank %0d energy %0h tag %0h",
             status_o, rank_o, found_energy_o, found_tag_o);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (status_o !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status_o);
      mismatches++;
    end
    if (rank_o !== want.rank) begin
      $error("rank: expected %0d, actual %0d", want.rank, rank_o);
      mismatches++;
    end
    if (found_energy_o !== want.energy) begin
      $error("found_energy: expected %0h, actual %0h", want.energy, found_energy_o);
      mismatches++;
    end
    if (found_tag_o !== want.tag) begin
      $error("found_tag: expected %0h, actual %0h", want.tag, found_tag_o);
      mismatches++;
    end
  endtask

  // Result side: pop at random, with two long hold-offs to back up the input
  initial begin : result_side
    int hold;
    int mode_left;
    bit steady;
    bit [1:0] pressed;
    hold      = 0;
    mode_left = 0;
    steady    = 1'b0;
    pressed   = '0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_reply();
      if (mode_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        mode_left = 100;
      end
      mode_left--;
      if (hold == 0 && !pressed[0] && replies_seen >= 30) begin
        hold       = LongHold;
        pressed[0] = 1'b1;
        n_holds++;
      end else if (hold == 0 && !pressed[1] && replies_seen >= 220) begin
        hold       = LongHold;
        pressed[1] = 1'b1;
        n_holds++;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 60) begin
        pop <= 1'b1;
      end else begin
        pop  <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus: directed script, random words, drain, verdict
  initial begin : stimulus
    script_row_t  script [18];
    lookup_word_t w;
    table_reply_t want;
    logic [EnergyW-1:0] target;
    int choice;

    model_count = 0;
    script = '{
      // lookups on an empty table, plain and saturated
      '{'{OP_LOOKUP, 32'h1234_5678, 32'd0, 8'hFF}, 1'b1, '{ST_EMPTY, 6'd0, 32'd0, 8'h00}},
      '{'{OP_LOOKUP, 32'd0, 32'hFFFF_FFFF, 8'h00}, 1'b1, '{ST_EMPTY, 6'd0, 32'd0, 8'h00}},
      // single entry; a query above it clamps to the top
      '{'{OP_INSERT, 32'd1000, 32'hFFFF_FFFF, 8'h5A}, 1'b1, '{ST_OK, 6'd0, 32'd0, 8'h00}},
      '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 8'h00}, 1'b1, '{ST_OK, 6'd0, 32'd1000, 8'h5A}},
      // fill 0, 1000 (ahead of the equal one), max, 2000
      '{'{OP_INSERT, 32'd0, 32'd0, 8'h00}, 1'b1, '{ST_OK, 6'd0, 32'd0, 8'h00}},
      '{'{OP_INSERT, 32'd1000, 32'd0, 8'hA5}, 1'b1, '{ST_OK, 6'd1, 32'd0, 8'h00}},
      '{'{OP_INSERT, 32'hFFFF_FFFF, 32'd0, 8'hFF}, 1'b1, '{ST_OK, 6'd3, 32'd0, 8'h00}},
      '{'{OP_INSERT, 32'd2000, 32'd0, 8'h3C}, 1'b1, '{ST_OK, 6'd3, 32'd0, 8'h00}},
      // exact ties go up, one off either side goes to the nearer entry
      '{'{OP_LOOKUP, 32'd500, 32'd0, 8'h00}, 1'b0, '0},
      '{'{OP_LOOKUP, 32'd499, 32'd0, 8'hFF}, 1'b0, '0},
      '{'{OP_LOOKUP, 32'd501, 32'd0, 8'h00}, 1'b0, '0},
      '{'{OP_LOOKUP, 32'd1500, 32'd0, 8'h00}, 1'b0, '0},
      // offset above energy saturates the query at zero; then top, zero and mid probes
      '{'{OP_LOOKUP, 32'd100, 32'd200, 8'hFF}, 1'b1, '{ST_OK, 6'd0, 32'd0, 8'h00}},
      '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 8'h00}, 1'b1, '{ST_OK, 6'd4, 32'hFFFF_FFFF, 8'hFF}},
      '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00}, 1'b1, '{ST_OK, 6'd0, 32'd0, 8'h00}},
      '{'{OP_INSERT, 32'h8000_0000, 32'h5555_5555, 8'h81}, 1'b1, '{ST_OK, 6'd4, 32'd0, 8'h00}},
      '{'{OP_LOOKUP, 32'hC000_0000, 32'd0, 8'h00}, 1'b0, '0},
      '{'{OP_LOOKUP, 32'hFFFF_FFFE, 32'd1, 8'h00}, 1'b0, '0}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      want = predict_table_reply(script[i].word);
      if (script[i].typed) want = script[i].reply;
      send_word(script[i].word, want);
    end

    // Random words: inserts thin out once the table is full
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 50 == 0) sender_steady = ($urandom_range(0, 2) == 0);
      w.tag = TagW'($urandom);
      if ($urandom_range(0, 99) < ((model_count < TableDepth) ? 45 : 15)) begin
        w.op     = OP_INSERT;
        w.energy = pick_energy();
        w.offset = $urandom;
      end else begin
        w.op   = OP_LOOKUP;
        target = pick_energy();
        choice = $urandom_range(0, 9);
        if (choice < 5)      w.offset = '0;
        else if (choice < 8) w.offset = EnergyW'($urandom_range(1, 3));
        else                 w.offset = $urandom;
        w.energy = (choice < 8) ? target + w.offset : target;
      end
      send_word(w, predict_table_reply(w));
    end
    push <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Inserts %0d (%0d dropped on a full table), lookups %0d (%0d on empty)",
             n_inserts, n_dropped, n_lookups, n_on_empty);
    $display("Lookup ties %0d, clamped to top %0d, saturated queries %0d, long holds %0d",
             n_ties, n_clamped, n_saturated, n_holds);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/stnl_pkg.sv
src/stnl_front.sv
src/stnl_queue.sv
src/stnl_engine.sv
src/sorted_table_nearest_lookup.sv
sim/sorted_table_nearest_lookup_tb.sv
